>>> hdl/cdt_sampler_table_family_unit_macros.svh
// Assertion macros used by the sampler controller.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef CDT_SAMPLER_TABLE_FAMILY_UNIT_MACROS_SVH
`define CDT_SAMPLER_TABLE_FAMILY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cstf_pkg.sv
// Shared types and constants of the distribution table sampler.
// No dependencies; used by the controller, datapath and top level.
package cstf_pkg;

  // Transaction command codes.
  typedef enum logic [1:0] {
    CMD_LOAD_THR  = 2'd0,
    CMD_LOAD_DESC = 2'd1,
    CMD_SAMPLE    = 2'd2
  } cmd_code_t;

  // Configuration port geometry and register map.
  localparam int CFG_AW = 3;
  localparam logic REG_TABLE_SELECT_OFFSET = 1'b0;

  // Per-table descriptor as stored in the descriptor RAM.
  typedef struct packed {
    logic [6:0]         count;
    logic [5:0]         prec;
    logic signed [14:0] offset;
  } desc_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic load_thr;
    logic load_desc;
    logic desc;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic no_table;
    logic short_tbl;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/cstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cstf_ctrl.sv
// Sequencing state machine of the sampler: load, descriptor fetch, scan, emit.
// Depends on cstf_pkg and the assertion macro header.
`include "cdt_sampler_table_family_unit_macros.svh"

module cstf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  output logic                  in_stall,
  input  cstf_pkg::dp_sts_t     sts,
  output cstf_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode state and handshake into datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            cstf_pkg::CMD_LOAD_THR:  cmd.load_thr  = 1'b1;
            cstf_pkg::CMD_LOAD_DESC: cmd.load_desc = 1'b1;
            cstf_pkg::CMD_SAMPLE: begin
              cmd.start = 1'b1;
              state_nxt = sts.no_table ? ST_EMIT : ST_DESC;
            end
            default: ;
          endcase
        end
      end
      ST_DESC: begin
        cmd.desc  = 1'b1;
        state_nxt = sts.short_tbl ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  `CSTF_ASSERT_NEXT(a_sample_leaves_idle, state_r == ST_IDLE && in_valid && in_cmd == cstf_pkg::CMD_SAMPLE, state_r != ST_IDLE, "sample transaction did not start a draw")
  `CSTF_ASSERT_NEXT(a_no_table_emits, state_r == ST_IDLE && in_valid && in_cmd == cstf_pkg::CMD_SAMPLE && sts.no_table, state_r == ST_EMIT, "out of range target skipped the emit step")
  `CSTF_ASSERT_NEXT(a_scan_ends_in_emit, state_r == ST_SCAN && sts.scan_done, state_r == ST_EMIT, "finished scan did not move to emit")

endmodule

>>> hdl/cstf_dp.sv
// Datapath of the sampler: table select, descriptor and threshold RAMs,
// descending scan with compare, result and output registers. Uses cstf_pkg, cstf_ram.
module cstf_dp #(
  parameter int NUM_TABLES  = 32,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cstf_pkg::ctrl_cmd_t         cmd,
  output cstf_pkg::dp_sts_t           sts,
  input  logic signed [14:0]          sel_offset,
  input  logic [4:0]                  in_table_index,
  input  logic [5:0]                  in_entry_index,
  input  logic [63:0]                 in_threshold_word,
  input  logic [6:0]                  in_entry_count,
  input  logic [5:0]                  in_precision_bits,
  input  logic signed [14:0]          in_value_offset,
  input  logic [63:0]                 in_random_word,
  input  logic signed [15:0]          in_target,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_sample_value,
  output logic                        out_no_table
);

  localparam int TW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int EW   = $clog2(MAX_ENTRIES);
  localparam int AW   = $clog2(NUM_TABLES * MAX_ENTRIES);
  localparam int CMPW = (EW + 1 > 7) ? EW + 1 : 7;

  // Table select from target.
  logic [16:0]   tsel;
  logic          no_table;
  logic [TW-1:0] sel;

  assign tsel     = {in_target[15], in_target} - {{2{sel_offset[14]}}, sel_offset};
  assign no_table = tsel[16] || (tsel[15:0] >= 16'(NUM_TABLES));
  assign sel      = TW'(tsel[15:0]);

  // Load address checks.
  logic tab_ok;
  logic ent_ok;

  assign tab_ok = 9'(in_table_index) < 9'(NUM_TABLES);
  assign ent_ok = 11'(in_entry_index) < 11'(MAX_ENTRIES);

  // Descriptor RAM.
  cstf_pkg::desc_t desc_wdata;
  cstf_pkg::desc_t desc_rdata;

  assign desc_wdata.count  = in_entry_count;
  assign desc_wdata.prec   = in_precision_bits;
  assign desc_wdata.offset = in_value_offset;

  cstf_ram #(
    .WIDTH ($bits(cstf_pkg::desc_t)),
    .DEPTH (NUM_TABLES)
  ) u_desc_ram (
    .clk   (clk),
    .we    (cmd.load_desc && tab_ok),
    .waddr (TW'(in_table_index)),
    .wdata (desc_wdata),
    .re    (cmd.start),
    .raddr (sel),
    .rdata (desc_rdata)
  );

  // Draw registers.
  logic [63:0]        rand_r;
  logic [TW-1:0]      sel_r;
  logic [63:0]        p_r;
  logic signed [14:0] base_r;
  logic [EW-1:0]      idx_r;
  logic [EW-1:0]      cmp_idx_r;
  logic               issue_r;
  logic               cmp_vld_r;
  logic [15:0]        res_r;
  logic               res_nt_r;

  // Descriptor decode: mask, capped count, first scan index.
  logic [63:0]     mask;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] cnt_cap;
  logic            short_tbl;
  logic [EW-1:0]   first_idx;

  assign mask      = (64'd1 << desc_rdata.prec) - 64'd1;
  assign cnt_ext   = CMPW'(desc_rdata.count);
  assign cnt_cap   = (cnt_ext > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : cnt_ext;
  assign short_tbl = cnt_cap < CMPW'(2);
  assign first_idx = EW'(cnt_cap - CMPW'(2));

  // Threshold RAM.
  logic [AW-1:0] thr_waddr;
  logic [AW-1:0] thr_raddr;
  logic [63:0]   thr_rdata;

  assign thr_waddr = AW'(AW'(TW'(in_table_index)) * AW'(MAX_ENTRIES)) + AW'(EW'(in_entry_index));
  assign thr_raddr = AW'(AW'(sel_r) * AW'(MAX_ENTRIES)) + AW'(idx_r);

  cstf_ram #(
    .WIDTH (64),
    .DEPTH (NUM_TABLES * MAX_ENTRIES)
  ) u_thr_ram (
    .clk   (clk),
    .we    (cmd.load_thr && tab_ok && ent_ok),
    .waddr (thr_waddr),
    .wdata (in_threshold_word),
    .re    (cmd.scan && issue_r),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  // Compare the entry read last cycle.
  logic        hit;
  logic        scan_done;
  logic [15:0] hit_value;

  assign hit       = p_r >= thr_rdata;
  assign scan_done = cmp_vld_r && (hit || (cmp_idx_r == '0));
  assign hit_value = 16'(base_r) + 16'(cmp_idx_r) + 16'd1;

  // Scan control bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.desc) begin
      issue_r   <= !short_tbl;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= issue_r;
      if (issue_r && idx_r == '0) begin
        issue_r <= 1'b0;
      end
    end else begin
      cmp_vld_r <= 1'b0;
    end
  end

  // Latch draw operands, walk the index down, capture the result.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rand_r   <= in_random_word;
      sel_r    <= sel;
      res_r    <= '0;
      res_nt_r <= no_table;
    end
    if (cmd.desc) begin
      p_r      <= rand_r & mask;
      base_r   <= desc_rdata.offset;
      idx_r    <= first_idx;
      res_r    <= 16'(desc_rdata.offset);
      res_nt_r <= 1'b0;
    end
    if (cmd.scan) begin
      cmp_idx_r <= idx_r;
      if (issue_r) begin
        idx_r <= idx_r - EW'(1);
      end
      if (cmp_vld_r && hit) begin
        res_r <= hit_value;
      end
    end
  end

  // Output register: valid bit.
  logic               out_valid_r;
  logic signed [15:0] out_value_r;
  logic               out_nt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= res_r;
      out_nt_r    <= res_nt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_no_table     = out_nt_r;

  assign sts.no_table  = no_table;
  assign sts.short_tbl = short_tbl;
  assign sts.scan_done = scan_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

>>> hdl/cdt_sampler_table_family_unit.sv
// Threshold and descriptor loads leave the block idle; a new transaction follows at once.
// A sample with an out-of-range target skips descriptor fetch and scan and goes to emit.
// A sample over a table of count entries (capped at MAX_ENTRIES) reads at most count - 1
// entries, one per cycle from the threshold RAM, between descriptor fetch and emit.
// Synchronous active-low reset clears control and the select offset; RAMs are not cleared.
module cdt_sampler_table_family_unit #(
  parameter int NUM_TABLES  = 32,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cstf_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [4:0]                  in_table_index,
  input  logic [5:0]                  in_entry_index,
  input  logic [63:0]                 in_threshold_word,
  input  logic [6:0]                  in_entry_count,
  input  logic [5:0]                  in_precision_bits,
  input  logic signed [14:0]          in_value_offset,
  input  logic [63:0]                 in_random_word,
  input  logic signed [15:0]          in_target,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_sample_value,
  output logic                        out_no_table
);

  // Select offset register.
  logic signed [14:0] sel_offset_r;
  logic               reg_hit;

  assign reg_hit = (paddr[2] == cstf_pkg::REG_TABLE_SELECT_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_offset_r <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      sel_offset_r <= pwdata[14:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? {17'd0, sel_offset_r} : 32'd0;

  cstf_pkg::ctrl_cmd_t cmd;
  cstf_pkg::dp_sts_t   sts;

  cstf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cstf_dp #(
    .NUM_TABLES  (NUM_TABLES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .sel_offset        (sel_offset_r),
    .in_table_index    (in_table_index),
    .in_entry_index    (in_entry_index),
    .in_threshold_word (in_threshold_word),
    .in_entry_count    (in_entry_count),
    .in_precision_bits (in_precision_bits),
    .in_value_offset   (in_value_offset),
    .in_random_word    (in_random_word),
    .in_target         (in_target),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_value  (out_sample_value),
    .out_no_table      (out_no_table)
  );

endmodule

>>> tb/tb_cdt_sampler_table_family_unit.sv
// Self-checking testbench for the distribution table sampler: loads, draws and select offset.
// Depends on cstf_pkg and cdt_sampler_table_family_unit; predicts every draw in its own model.
module tb_cdt_sampler_table_family_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TABLES     = 32;
  localparam int MAX_ENTRIES    = 64;
  localparam int TAIL_CYCLES    = MAX_ENTRIES + 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CFG_AW         = cstf_pkg::CFG_AW;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] SEL_OFF_ADDR =
    CFG_AW'(4 * int'(cstf_pkg::REG_TABLE_SELECT_OFFSET));

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         tbl;
    logic [5:0]         ent;
    logic [63:0]        thr;
    logic [6:0]         cnt;
    logic [5:0]         prec;
    logic signed [14:0] voff;
    logic [63:0]        rword;
    logic signed [15:0] tgt;
  } sampler_req_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               no_tbl;
  } draw_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [1:0] in_cmd;
  logic [4:0] in_table_index;
  logic [5:0] in_entry_index;
  logic [63:0] in_threshold_word;
  logic [6:0] in_entry_count;
  logic [5:0] in_precision_bits;
  logic signed [14:0] in_value_offset;
  logic [63:0] in_random_word;
  logic signed [15:0] in_target;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample_value;
  logic out_no_table;

  // Predictor state: threshold store, descriptors and the select offset
  logic [63:0] thr_mem [NUM_TABLES*MAX_ENTRIES];
  cstf_pkg::desc_t desc_mem [NUM_TABLES];
  logic signed [14:0] sel_off_reg;
  // Which entries have been written, so no draw reads an unwritten one
  bit thr_seen [NUM_TABLES*MAX_ENTRIES];
  bit desc_seen [NUM_TABLES];

  draw_result_t pending_draws[$];
  bit quiet_mode = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_draws = 0;
  int n_results = 0;
  int n_misses = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  cdt_sampler_table_family_unit #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_table_index   (in_table_index),
    .in_entry_index   (in_entry_index),
    .in_threshold_word(in_threshold_word),
    .in_entry_count   (in_entry_count),
    .in_precision_bits(in_precision_bits),
    .in_value_offset  (in_value_offset),
    .in_random_word   (in_random_word),
    .in_target        (in_target),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_no_table     (out_no_table)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Inversion lookup: highest entry at or below the masked word, scanned from the top
  function automatic draw_result_t draw_outcome(logic [63:0] rword, logic signed [15:0] tgt);
    draw_result_t r;
    cstf_pkg::desc_t d;
    int sel;
    int lim;
    int pick;
    int i;
    bit hit;
    logic [63:0] masked;
    r.value = '0;
    r.no_tbl = 1'b1;
    sel = int'(tgt) - int'(sel_off_reg);
    if (sel < 0 || sel >= NUM_TABLES) return r;
    d = desc_mem[sel];
    masked = rword & ((64'd1 << d.prec) - 64'd1);
    lim = int'(d.count);
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    pick = int'($signed(d.offset));
    hit = 1'b0;
    for (i = lim - 2; i >= 0; i--) begin
      if (!hit && masked >= thr_mem[sel*MAX_ENTRIES + i]) begin
        pick = int'($signed(d.offset)) + i + 1;
        hit = 1'b1;
      end
    end
    r.value = 16'(pick);
    r.no_tbl = 1'b0;
    return r;
  endfunction

  // Update the model with one accepted transaction
  function automatic void record_item(sampler_req_t it);
    int slot;
    slot = int'(it.tbl) * MAX_ENTRIES + int'(it.ent);
    case (it.cmd)
      cstf_pkg::CMD_LOAD_THR: begin
        thr_mem[slot] = it.thr;
        thr_seen[slot] = 1'b1;
        n_items++;
      end
      cstf_pkg::CMD_LOAD_DESC: begin
        desc_mem[it.tbl].count = it.cnt;
        desc_mem[it.tbl].prec = it.prec;
        desc_mem[it.tbl].offset = it.voff;
        desc_seen[it.tbl] = 1'b1;
        n_items++;
      end
      cstf_pkg::CMD_SAMPLE: begin
        pending_draws.push_back(draw_outcome(it.rword, it.tgt));
        n_items++;
        n_draws++;
      end
      default: ;
    endcase
  endfunction

  // A table may be drawn from once its descriptor and every scanned entry are written
  function automatic bit table_ready(int t);
    int lim;
    int i;
    bit ok;
    if (!desc_seen[t]) return 1'b0;
    lim = int'(desc_mem[t].count);
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    ok = 1'b1;
    for (i = 0; i < lim - 1; i++)
      if (!thr_seen[t*MAX_ENTRIES + i]) ok = 1'b0;
    return ok;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [6:0] random_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 7'($urandom_range(2, 8));
    if (roll < 85) return 7'($urandom_range(9, MAX_ENTRIES));
    if (roll < 93) return 7'($urandom_range(1));
    return 7'($urandom_range(MAX_ENTRIES + 1, 127));
  endfunction

  // Fill every field at random; callers override the ones the command uses
  function automatic sampler_req_t noise_item(logic [1:0] cmd);
    sampler_req_t it;
    it.cmd   = cmd;
    it.tbl   = 5'($urandom);
    it.ent   = 6'($urandom);
    it.thr   = rand64();
    it.cnt   = 7'($urandom);
    it.prec  = 6'($urandom);
    it.voff  = 15'($urandom);
    it.rword = rand64();
    it.tgt   = 16'($urandom);
    return it;
  endfunction

  // Drive one transaction after a random gap and hold it until accepted
  task automatic send_item(input sampler_req_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= it.cmd;
    in_table_index    <= it.tbl;
    in_entry_index    <= it.ent;
    in_threshold_word <= it.thr;
    in_entry_count    <= it.cnt;
    in_precision_bits <= it.prec;
    in_value_offset   <= it.voff;
    in_random_word    <= it.rword;
    in_target         <= it.tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_item(it);
  endtask

  task automatic send_thr(input int t, input int e, input logic [63:0] w);
    sampler_req_t it;
    it = noise_item(cstf_pkg::CMD_LOAD_THR);
    it.tbl = 5'(t);
    it.ent = 6'(e);
    it.thr = w;
    send_item(it);
  endtask

  task automatic send_desc(input int t, input logic [6:0] cnt, input logic [5:0] prec,
                           input logic signed [14:0] voff);
    sampler_req_t it;
    it = noise_item(cstf_pkg::CMD_LOAD_DESC);
    it.tbl = 5'(t);
    it.cnt = cnt;
    it.prec = prec;
    it.voff = voff;
    send_item(it);
  endtask

  task automatic send_draw(input logic [63:0] rword, input logic signed [15:0] tgt);
    sampler_req_t it;
    it = noise_item(cstf_pkg::CMD_SAMPLE);
    it.rword = rword;
    it.tgt = tgt;
    send_item(it);
  endtask

  // Draw from a ready table, often landing on or just under a stored threshold
  task automatic draw_from(input int t);
    logic [63:0] mask, rw;
    int lim;
    int e;
    int roll;
    mask = (64'd1 << desc_mem[t].prec) - 64'd1;
    lim = int'(desc_mem[t].count);
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    roll = $urandom_range(9);
    rw = rand64();
    if (roll < 4 && lim >= 2) begin
      e = $urandom_range(lim - 2);
      rw = (rw & ~mask) | ((thr_mem[t*MAX_ENTRIES + e] - 64'($urandom_range(1))) & mask);
    end else if (roll == 4) begin
      rw = '1;
    end else if (roll == 5) begin
      rw = '0;
    end
    send_draw(rw, 16'(t + int'(sel_off_reg)));
  endtask

  // Draw from some ready table, or aim at a target outside the family
  task automatic draw_any();
    int t;
    int tries;
    logic signed [15:0] tgt;
    bit done;
    done = 1'b0;
    if ($urandom_range(3) != 0) begin
      t = $urandom_range(NUM_TABLES - 1);
      tries = 0;
      while (!table_ready(t) && tries < NUM_TABLES) begin
        t = (t + 1) % NUM_TABLES;
        tries++;
      end
      if (table_ready(t)) begin
        draw_from(t);
        done = 1'b1;
      end
    end
    if (!done) begin
      tgt = 16'($urandom);
      t = int'(tgt) - int'(sel_off_reg);
      if (t >= 0 && t < NUM_TABLES && !table_ready(t)) tgt = 16'(int'(sel_off_reg) - 1);
      send_draw(rand64(), tgt);
    end
  endtask

  // Load a descriptor and every scanned threshold, mostly ascending, then draw a few
  task automatic build_table(input int t, input logic [6:0] cnt, input logic [5:0] prec);
    logic [63:0] mask, span, w;
    int n;
    int i;
    int k;
    send_desc(t, cnt, prec, 15'($urandom));
    n = int'(cnt);
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    n = n - 1;
    mask = (64'd1 << prec) - 64'd1;
    span = (n > 0) ? mask / 64'(n + 1) : 64'd0;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) w = rand64();
      else if (span == 0) w = rand64() & mask;
      else w = 64'(i) * span + rand64() % span;
      send_thr(t, i, w);
    end
    k = $urandom_range(1, 4);
    for (i = 0; i < k; i++) draw_from(t);
  endtask

  // Stop sending, let every expected result arrive, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEL_OFF_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic signed [14:0] want);
    logic [31:0] rd;
    cfg_access(1'b0, 32'd0, rd);
    if (rd[14:0] !== want) begin
      errors++;
      $display("%0t: select offset read expected %0d got %0d", $time, want, $signed(rd[14:0]));
    end
  endtask

  // Extremes of every field and each corner of the lookup, offset at its reset value
  task automatic test_directed_cases();
    cfg_check(15'sd0);
    // full precision, three outcomes, lowest value offset
    send_desc(0, 7'd3, 6'd63, -15'sd16384);
    send_thr(0, 0, 64'd100);
    send_thr(0, 1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_draw(64'd0, 16'sd0);
    send_draw(64'd99, 16'sd0);
    send_draw(64'd100, 16'sd0);
    send_draw('1, 16'sd0);
    // count of one scans nothing, highest value offset
    send_desc(NUM_TABLES - 1, 7'd1, 6'd1, 15'sd16383);
    send_draw('1, 16'(NUM_TABLES - 1));
    // count of zero
    send_desc(2, 7'd0, 6'd5, 15'sd5);
    send_draw(rand64(), 16'sd2);
    // precision zero masks the whole word away
    send_desc(3, 7'd2, 6'd0, -15'sd1);
    send_thr(3, 0, 64'd0);
    send_draw('1, 16'sd3);
    // targets that select no table
    send_draw(rand64(), 16'(NUM_TABLES));
    send_draw(rand64(), -16'sd1);
    send_draw(rand64(), -16'sd32768);
    send_draw(rand64(), 16'sd32767);
    send_item(noise_item(CMD_UNUSED));
  endtask

  // Counts above the table depth are capped to the full depth
  task automatic test_count_cap();
    build_table(5, 7'd127, 6'($urandom_range(40, 63)));
    build_table(6, 7'd64, 6'd63);
    send_desc(5, 7'd64, desc_mem[5].prec, desc_mem[5].offset);
    repeat (3) draw_from(5);
  endtask

  // Mostly well-formed table builds and draws, with stray loads and unused commands
  task automatic test_random_traffic(input int n);
    int stop;
    int roll;
    stop = n_items + n;
    while (n_items < stop) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        build_table($urandom_range(NUM_TABLES - 1), random_count(),
                    ($urandom_range(15) == 0) ? 6'd0 : 6'($urandom_range(1, 63)));
      end else if (roll < 80) begin
        draw_any();
      end else if (roll < 88) begin
        send_thr($urandom_range(NUM_TABLES - 1), $urandom_range(MAX_ENTRIES - 1), rand64());
      end else if (roll < 93) begin
        send_desc($urandom_range(NUM_TABLES - 1), random_count(), 6'($urandom), 15'($urandom));
      end else if (roll < 97) begin
        send_item(noise_item(CMD_UNUSED));
      end else begin
        wait_drained();
      end
    end
  endtask

  // Move the select offset while idle, read it back, then run traffic under it
  task automatic test_select_offset(input logic signed [14:0] off, input int n);
    logic [31:0] rd;
    wait_drained();
    cfg_access(1'b1, {{17{off[14]}}, off}, rd);
    sel_off_reg = off;
    n_settings++;
    cfg_check(off);
    test_random_traffic(n);
  endtask

  // Traffic with no gaps on either side
  task automatic test_back_to_back(input int n);
    wait_drained();
    quiet_mode = 1'b1;
    test_random_traffic(n);
    wait_drained();
    quiet_mode = 1'b0;
  endtask

  // Compare each accepted result with the oldest prediction; stall the output at random
  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_draws.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: sample_value %0d no_table %0b",
                 $time, out_sample_value, out_no_table);
      end else begin
        want = pending_draws.pop_front();
        if (want.no_tbl) n_misses++;
        if (out_sample_value !== want.value) begin
          errors++;
          $display("%0t: sample_value expected %0d got %0d", $time, $signed(want.value),
                   out_sample_value);
        end
        if (out_no_table !== want.no_tbl) begin
          errors++;
          $display("%0t: no_table expected %0b got %0b", $time, want.no_tbl, out_no_table);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet_mode) begin
        case ($urandom_range(99)) inside
          [0:2]:   stall_left = $urandom_range(12, 40);
          [3:19]:  stall_left = $urandom_range(1, 3);
          default: stall_left = 0;
        endcase
      end
    end
  end

  // End the run when neither channel nor the config port moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid          = 1'b0;
    in_cmd            = cstf_pkg::CMD_LOAD_THR;
    in_table_index    = '0;
    in_entry_index    = '0;
    in_threshold_word = '0;
    in_entry_count    = '0;
    in_precision_bits = '0;
    in_value_offset   = '0;
    in_random_word    = '0;
    in_target         = '0;
    sel_off_reg       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_count_cap();
    test_random_traffic(150);
    test_select_offset(-15'sd16384, 100);
    test_select_offset(15'sd16383, 100);
    test_back_to_back(100);
    test_select_offset(15'($urandom), 100);
    wait_drained();

    $display("Covered %0d transactions, %0d draws, %0d results (%0d outside the table family)",
             n_items, n_draws, n_results, n_misses);
    $display("Select offset settings applied: %0d, mismatches: %0d", n_settings, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/cstf_pkg.sv
hdl/cstf_ram.sv
hdl/cstf_ctrl.sv
hdl/cstf_dp.sv
hdl/cdt_sampler_table_family_unit.sv
tb/tb_cdt_sampler_table_family_unit.sv
